// ===== rtl/setc_pkg.sv =====
// types and constants for the scope edge trigger capture unit
// no dependencies; used by scope_edge_trigger_capture_unit
package setc_pkg;

  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 16;
  localparam int FRAC_OUT_W = 16;
  localparam int LEVEL_W    = 31;
  localparam int LENGTH_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LENGTH = 2'd1;

  localparam logic [LEVEL_W-1:0]  TRIGGER_LEVEL_RST  = 31'd5000000;
  localparam logic [LENGTH_W-1:0] CAPTURE_LENGTH_RST = 16'd2000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_in;
    logic                      frame_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] point_value;
    logic [INDEX_W-1:0]        point_index;
    logic [FRAC_OUT_W-1:0]     crossing_fraction;
    logic                      capture_last;
  } out_item_t;

endpackage

// ===== rtl/scope_edge_trigger_capture_unit.sv =====
// rising edge trigger with zero crossing interpolation and point capture
// depends on setc_pkg for payload types, register indexes and reset values
//
// channel  direction  handshake          payload
// in_      input      in_valid/in_ready  setc_pkg::in_item_t
// out_     output     out_valid/out_ready setc_pkg::out_item_t
// cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// sample during capture: its result is loaded into the output register
// trigger sample: the restoring divider (one quotient bit a cycle) forms the fraction,
// then one or two result transfers (one if the length is one) through one output register
// in_ready is low while dividing or emitting, or while the output holds an untaken result
// synchronous active-low reset; control state and configuration registers return to defaults
module scope_edge_trigger_capture_unit #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  setc_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output setc_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [setc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [setc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int RW    = SAMPLE_WIDTH + 1;
  localparam int CW    = ((SAMPLE_WIDTH > setc_pkg::LEVEL_W) ? SAMPLE_WIDTH
                                                            : setc_pkg::LEVEL_W) + 1;
  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_EMIT0 = 2'd2;
  localparam logic [1:0] S_EMIT1 = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [setc_pkg::LEVEL_W-1:0]    trig_level_r;
  logic [setc_pkg::LENGTH_W-1:0]   cap_len_r;
  logic signed [SAMPLE_WIDTH-1:0]  prev_sample_r;
  logic                            prev_valid_r;
  logic                            capturing_r;
  logic [setc_pkg::INDEX_W-1:0]    points_r;
  logic [FRACTION_BITS-1:0]        held_frac_r;
  logic                            out_valid_r;
  setc_pkg::out_item_t             out_r;

  logic signed [SAMPLE_WIDTH-1:0]  trig_prev_r;
  logic signed [SAMPLE_WIDTH-1:0]  trig_cur_r;
  logic [RW-1:0]                   rem_r;
  logic [SAMPLE_WIDTH-1:0]         den_r;
  logic [FRACTION_BITS-1:0]        quot_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            sat_r;
  logic                            len_one_r;
  logic                            last1_r;

  logic                            out_free;
  logic                            accept;
  logic signed [SAMPLE_WIDTH-1:0]  cur;
  logic                            fend;
  logic [setc_pkg::LENGTH_W-1:0]   len;
  logic signed [CW-1:0]            cur_ext;
  logic signed [CW-1:0]            level_ext;
  logic                            fire;
  logic [setc_pkg::INDEX_W-1:0]    pe_next;
  logic                            cap_last;
  logic signed [RW-1:0]            prev_wide;
  logic signed [RW-1:0]            cur_wide;
  logic [RW-1:0]                   rem_sh;
  logic                            div_ge;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cur       = in_data.sample_in[SAMPLE_WIDTH-1:0];
  assign fend      = in_data.frame_last;
  assign len       = (cap_len_r == '0) ? setc_pkg::LENGTH_W'(1) : cap_len_r;
  assign cur_ext   = CW'(cur);
  assign level_ext = $signed(CW'(trig_level_r));
  assign fire      = prev_valid_r && (prev_sample_r <= 0) && (cur_ext >= level_ext) &&
                     (cur > prev_sample_r);
  assign pe_next   = points_r + setc_pkg::INDEX_W'(1);
  assign cap_last  = fend ||
                     ({1'b0, pe_next} + 17'd1 >= {1'b0, len});
  assign prev_wide = RW'(prev_sample_r);
  assign cur_wide  = RW'(cur);
  assign rem_sh    = {rem_r[RW-2:0], 1'b0};
  assign div_ge    = rem_sh >= RW'(den_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !capturing_r && fire) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(1)) state_nxt = S_EMIT0;
      end
      S_EMIT0: begin
        if (out_free) state_nxt = len_one_r ? S_IDLE : S_EMIT1;
      end
      S_EMIT1: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      trig_level_r <= setc_pkg::TRIGGER_LEVEL_RST;
      cap_len_r    <= setc_pkg::CAPTURE_LENGTH_RST;
      prev_sample_r <= '0;
      prev_valid_r <= 1'b0;
      capturing_r  <= 1'b0;
      points_r     <= '0;
      held_frac_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          setc_pkg::REG_TRIGGER_LEVEL:  trig_level_r <= cfg_wdata[setc_pkg::LEVEL_W-1:0];
          setc_pkg::REG_CAPTURE_LENGTH: cap_len_r    <= cfg_wdata[setc_pkg::LENGTH_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      if (accept) begin
        prev_sample_r <= cur;
        prev_valid_r  <= !fend;
        if (capturing_r) begin
          out_valid_r <= 1'b1;
          if (cap_last) begin
            capturing_r <= 1'b0;
            points_r    <= '0;
          end else begin
            points_r <= pe_next;
          end
        end else if (fire) begin
          if (len == setc_pkg::LENGTH_W'(1) || fend || len <= setc_pkg::LENGTH_W'(2)) begin
            points_r <= '0;
          end else begin
            capturing_r <= 1'b1;
            points_r    <= setc_pkg::INDEX_W'(1);
          end
        end
      end

      if (state_r == S_DIV && cnt_r == CNT_W'(1)) begin
        held_frac_r <= sat_r ? '1 : {quot_r[FRACTION_BITS-2:0], div_ge};
      end

      if ((state_r == S_EMIT0 || state_r == S_EMIT1) && out_free) out_valid_r <= 1'b1;
    end
  end

  // datapath registers: capture payload, divider
  always_ff @(posedge clk) begin
    if (accept && capturing_r) begin
      out_r.point_value       <= setc_pkg::VALUE_W'(cur);
      out_r.point_index       <= pe_next;
      out_r.crossing_fraction <= setc_pkg::FRAC_OUT_W'(held_frac_r);
      out_r.capture_last      <= cap_last;
    end else if (state_r == S_EMIT0 && out_free) begin
      out_r.point_value       <= setc_pkg::VALUE_W'(trig_prev_r);
      out_r.point_index       <= '0;
      out_r.crossing_fraction <= setc_pkg::FRAC_OUT_W'(held_frac_r);
      out_r.capture_last      <= len_one_r;
    end else if (state_r == S_EMIT1 && out_free) begin
      out_r.point_value       <= setc_pkg::VALUE_W'(trig_cur_r);
      out_r.point_index       <= setc_pkg::INDEX_W'(1);
      out_r.crossing_fraction <= setc_pkg::FRAC_OUT_W'(held_frac_r);
      out_r.capture_last      <= last1_r;
    end

    if (accept && !capturing_r && fire) begin
      trig_prev_r <= prev_sample_r;
      trig_cur_r  <= cur;
      rem_r       <= -prev_wide;
      den_r       <= SAMPLE_WIDTH'(cur_wide - prev_wide);
      sat_r       <= (cur == 0);
      cnt_r       <= CNT_W'(FRACTION_BITS);
      quot_r      <= '0;
      len_one_r   <= (len == setc_pkg::LENGTH_W'(1));
      last1_r     <= fend || (len <= setc_pkg::LENGTH_W'(2));
    end else if (state_r == S_DIV) begin
      // one restoring step per cycle
      rem_r  <= div_ge ? rem_sh - RW'(den_r) : rem_sh;
      quot_r <= {quot_r[FRACTION_BITS-2:0], div_ge};
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input ready outside idle");

  a_capture_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && capturing_r) |=> out_valid_r)
    else $error("capture sample gave no result");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_EMIT0))
    else $error("divider left early");

  a_trigger_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT0 && out_free) |=> (out_valid_r && out_r.point_index == '0))
    else $error("first point of capture not index zero");

endmodule
